@@ hdl/dss_pkg.sv @@
// Package with the word types, codes and coil tables of the dual stepper sequencer.
package dss_pkg;

	// Input word: a time tick or a move command.
	typedef struct packed {
		logic       kind;
		logic [2:0] move_mode;
		logic       half_step;
		logic [7:0] cycles;
	} in_word_t;

	// Result word: both coil patterns and the move status.
	typedef struct packed {
		logic [3:0] right_coils;
		logic [3:0] left_coils;
		logic       busy_res;
		logic       done_res;
	} out_word_t;

	// Input word kinds.
	localparam logic KIND_TICK  = 1'b0;
	localparam logic KIND_START = 1'b1;

	// Move modes.
	localparam logic [2:0] MODE_BOTH_FWD   = 3'd0;
	localparam logic [2:0] MODE_BOTH_BACK  = 3'd1;
	localparam logic [2:0] MODE_SPOT_RIGHT = 3'd2;
	localparam logic [2:0] MODE_SPOT_LEFT  = 3'd3;
	localparam logic [2:0] MODE_LEFT_FWD   = 3'd4;
	localparam logic [2:0] MODE_LEFT_BACK  = 3'd5;
	localparam logic [2:0] MODE_RIGHT_FWD  = 3'd6;
	localparam logic [2:0] MODE_RIGHT_BACK = 3'd7;

	// Configuration register indexes.
	localparam logic CFG_ON_TIME  = 1'b0;
	localparam logic CFG_OFF_TIME = 1'b1;

	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 16;

	// Register reset values.
	localparam logic [15:0] ON_TIME_RESET  = 16'd7000;
	localparam logic [15:0] OFF_TIME_RESET = 16'd1;

	// Pattern held by a motor that does not move in a single-wheel mode.
	localparam logic [3:0] HOLD_PATTERN = 4'h3;

	// Last phase of a half-step and of a full-step cycle.
	localparam logic [2:0] LAST_HALF = 3'd7;
	localparam logic [2:0] LAST_FULL = 3'd3;

	// Motor direction.
	typedef enum logic [1:0] {
		DIR_FWD,
		DIR_BACK,
		DIR_HOLD
	} dir_t;

	// Direction of the right motor for a move mode.
	function automatic dir_t right_dir(input logic [2:0] mode);
		dir_t d;
		unique case (mode)
			MODE_BOTH_FWD:   d = DIR_FWD;
			MODE_BOTH_BACK:  d = DIR_BACK;
			MODE_SPOT_RIGHT: d = DIR_FWD;
			MODE_SPOT_LEFT:  d = DIR_BACK;
			MODE_LEFT_FWD:   d = DIR_HOLD;
			MODE_LEFT_BACK:  d = DIR_HOLD;
			MODE_RIGHT_FWD:  d = DIR_FWD;
			MODE_RIGHT_BACK: d = DIR_BACK;
			default:         d = DIR_HOLD;
		endcase
		return d;
	endfunction

	// Direction of the left motor for a move mode.
	function automatic dir_t left_dir(input logic [2:0] mode);
		dir_t d;
		unique case (mode)
			MODE_BOTH_FWD:   d = DIR_FWD;
			MODE_BOTH_BACK:  d = DIR_BACK;
			MODE_SPOT_RIGHT: d = DIR_BACK;
			MODE_SPOT_LEFT:  d = DIR_FWD;
			MODE_LEFT_FWD:   d = DIR_FWD;
			MODE_LEFT_BACK:  d = DIR_BACK;
			MODE_RIGHT_FWD:  d = DIR_HOLD;
			MODE_RIGHT_BACK: d = DIR_HOLD;
			default:         d = DIR_HOLD;
		endcase
		return d;
	endfunction

	// Forward half-step sequence.
	function automatic logic [3:0] fwd_half(input logic [2:0] p);
		logic [3:0] c;
		unique case (p)
			3'd0:    c = 4'h3;
			3'd1:    c = 4'h2;
			3'd2:    c = 4'h6;
			3'd3:    c = 4'h4;
			3'd4:    c = 4'hC;
			3'd5:    c = 4'h8;
			3'd6:    c = 4'h9;
			3'd7:    c = 4'h1;
			default: c = 4'h0;
		endcase
		return c;
	endfunction

	// Forward full-step sequence.
	function automatic logic [3:0] fwd_full(input logic [1:0] p);
		logic [3:0] c;
		unique case (p)
			2'd0:    c = 4'h3;
			2'd1:    c = 4'h6;
			2'd2:    c = 4'hC;
			2'd3:    c = 4'h9;
			default: c = 4'h0;
		endcase
		return c;
	endfunction

	// Coils of one motor for its direction, the phase and the gap flag.
	// Backward runs the table from its end, which is the bitwise inverse of the index.
	function automatic logic [3:0] coil_pattern(input dir_t d, input logic [2:0] phase,
			input logic half, input logic gap);
		logic [3:0] c;
		logic [2:0] p;
		p = (d == DIR_FWD) ? phase : ~phase;
		if (d == DIR_HOLD) begin
			c = HOLD_PATTERN;
		end else if (gap) begin
			c = 4'h0;
		end else if (half) begin
			c = fwd_half(p);
		end else begin
			c = fwd_full(p[1:0]);
		end
		return c;
	endfunction

endpackage

@@ hdl/dss_seq.sv @@
// Sequencer state, timing registers and the per-word step and coil logic.
module dss_seq (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [dss_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dss_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                        step,
	input  dss_pkg::in_word_t           word,
	output dss_pkg::out_word_t          res
);
	import dss_pkg::*;

	logic [15:0] on_time_q;
	logic [15:0] off_time_q;
	logic [2:0]  mode_q;
	logic        half_q;
	logic [2:0]  phase_q;
	logic [7:0]  cycles_left_q;
	logic [15:0] timer_q;
	logic        gap_q;
	logic        running_q;

	logic [2:0]  mode_d;
	logic        half_d;
	logic [2:0]  phase_d;
	logic [7:0]  cycles_left_d;
	logic [15:0] timer_d;
	logic        gap_d;
	logic        running_d;

	logic [15:0] seg_len;
	logic [16:0] timer_inc;
	logic        seg_end;
	logic [2:0]  last_phase;
	logic [7:0]  cycles_dec;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_time_q  <= ON_TIME_RESET;
			off_time_q <= OFF_TIME_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ON_TIME:  on_time_q  <= cfg_data;
				CFG_OFF_TIME: off_time_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Segment length and end test; a zero on time counts as one tick.
	always_comb begin
		if (gap_q) begin
			seg_len = off_time_q;
		end else if (on_time_q == '0) begin
			seg_len = 16'd1;
		end else begin
			seg_len = on_time_q;
		end
		timer_inc  = {1'b0, timer_q} + 17'd1;
		seg_end    = timer_inc >= {1'b0, seg_len};
		last_phase = half_q ? LAST_HALF : LAST_FULL;
		cycles_dec = cycles_left_q - 8'd1;
	end

	// Next state and result for the word being processed.
	always_comb begin
		mode_d        = mode_q;
		half_d        = half_q;
		phase_d       = phase_q;
		cycles_left_d = cycles_left_q;
		timer_d       = timer_q;
		gap_d         = gap_q;
		running_d     = running_q;
		res           = '0;

		if (word.kind == KIND_START) begin
			mode_d        = word.move_mode;
			half_d        = word.half_step;
			cycles_left_d = word.cycles;
			phase_d       = '0;
			timer_d       = '0;
			gap_d         = 1'b0;
			running_d     = word.cycles != '0;
		end else if (running_q) begin
			res.right_coils = coil_pattern(right_dir(mode_q), phase_q, half_q, gap_q);
			res.left_coils  = coil_pattern(left_dir(mode_q), phase_q, half_q, gap_q);
			timer_d = timer_inc[15:0];
			if (seg_end) begin
				timer_d = '0;
				if (!gap_q && off_time_q != '0) begin
					gap_d = 1'b1;
				end else begin
					gap_d = 1'b0;
					if (phase_q >= last_phase) begin
						phase_d       = '0;
						cycles_left_d = cycles_dec;
						if (cycles_dec == '0) begin
							running_d    = 1'b0;
							res.done_res = 1'b1;
						end
					end else begin
						phase_d = phase_q + 3'd1;
					end
				end
			end
		end
		res.busy_res = running_d;
	end

	// Sequencer state, advanced once per processed word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= '0;
			half_q        <= 1'b0;
			phase_q       <= '0;
			cycles_left_q <= '0;
			timer_q       <= '0;
			gap_q         <= 1'b0;
			running_q     <= 1'b0;
		end else if (step) begin
			mode_q        <= mode_d;
			half_q        <= half_d;
			phase_q       <= phase_d;
			cycles_left_q <= cycles_left_d;
			timer_q       <= timer_d;
			gap_q         <= gap_d;
			running_q     <= running_d;
		end
	end

endmodule

@@ hdl/dual_stepper_sequencer.sv @@
// Top level of the dual stepper sequencer: input register, sequencer and result register.
//
// The block takes one word per clock cycle while its results are taken and returns one
// result word for each: a tick word gives the coils of both motors driven during that
// tick, a start word loads a new move and returns coils off. An accepted word sits in
// the input register until the result register is empty or being emptied; the edge
// that moves it on steps the sequencer and loads the result register, which raises
// out_valid. The sequencer state is updated once per word. While the result register
// holds a word that is not taken, a word in the input register stays there and in_ready
// is low in that same cycle. The user must write the on and off times through the
// configuration port only while no word is in flight; the block does not enforce this.
module dual_stepper_sequencer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [dss_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dss_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  dss_pkg::in_word_t              in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output dss_pkg::out_word_t             out_data
);
	import dss_pkg::*;

	in_word_t  word_s1;
	logic      valid_s1;
	out_word_t res;
	out_word_t res_q;
	logic      res_valid_q;
	logic      advance;

	// A word moves on when the result register is empty or being emptied.
	assign advance  = valid_s1 && (!res_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_s1 <= in_data;
		end
	end

	// Sequencer core.
	dss_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step      (advance),
		.word      (word_s1),
		.res       (res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (out_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_valid = res_valid_q;
	assign out_data  = res_q;

endmodule

@@ hdl/dss_checker.sv @@
// Port checker for the dual stepper sequencer and its bind to the top level.
module dss_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input dss_pkg::out_word_t out_data
);
	import dss_pkg::*;

	// The done mark ends the move, so busy is already low with it.
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.done_res |-> !out_data.busy_res)
		else $error("done word still reports busy");

	// A word that is neither busy nor done drives no coils.
	a_idle_coils_off: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.busy_res && !out_data.done_res |->
		out_data.right_coils == 4'h0 && out_data.left_coils == 4'h0)
		else $error("coils driven on an idle word");

	// The input side stalls only behind a result that is not taken.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output backpressure");

	// A stalled result holds its word.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

endmodule

bind dual_stepper_sequencer dss_checker u_dss_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

@@ verif/dual_stepper_sequencer_test.sv @@
// Self-checking testbench of the dual stepper sequencer with its own sequence predictor.
`timescale 1ns / 100ps

module dual_stepper_sequencer_test;
	import dss_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned REPORT_MAX = 10;
	// Forward half-step coil sequence, phase 0 in the low nibble.
	localparam logic [31:0] HALF_SEQ = 32'h1_9_8_C_4_6_2_3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_word_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_word_t out_data;

	// Words waiting for the driver, and coil results waiting for the DUT.
	in_word_t pending_words[$];
	out_word_t expected_results[$];
	int unsigned words_queued = 0;
	int unsigned results_seen = 0;
	int unsigned fail_count = 0;
	int unsigned cycle_count = 0;
	int unsigned sender_idle_pct = 0;
	int unsigned recv_stall_pct = 0;

	// Predicted sequencer state and timing registers.
	logic [15:0] on_ticks = ON_TIME_RESET;
	logic [15:0] off_ticks = OFF_TIME_RESET;
	logic [2:0] mv_mode = '0;
	logic mv_half = 1'b0;
	logic [2:0] mv_phase = '0;
	logic [7:0] mv_cycles_left = '0;
	logic [16:0] seg_timer = '0;
	logic in_gap = 1'b0;
	logic moving = 1'b0;

	dual_stepper_sequencer dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always #10 clk = ~clk;

	// Direction of one wheel for a move mode.
	function automatic dir_t wheel_dir(input logic [2:0] mode, input logic is_left);
		dir_t d;
		case (mode)
			MODE_BOTH_FWD:   d = DIR_FWD;
			MODE_BOTH_BACK:  d = DIR_BACK;
			MODE_SPOT_RIGHT: d = is_left ? DIR_BACK : DIR_FWD;
			MODE_SPOT_LEFT:  d = is_left ? DIR_FWD : DIR_BACK;
			MODE_LEFT_FWD:   d = is_left ? DIR_FWD : DIR_HOLD;
			MODE_LEFT_BACK:  d = is_left ? DIR_BACK : DIR_HOLD;
			MODE_RIGHT_FWD:  d = is_left ? DIR_HOLD : DIR_FWD;
			default:         d = is_left ? DIR_HOLD : DIR_BACK;
		endcase
		return d;
	endfunction

	// Coils of one motor. A full step is every second entry of the half-step sequence.
	function automatic logic [3:0] motor_coils(input dir_t d, input logic [2:0] ph,
			input logic half, input logic gap);
		logic [2:0] idx;
		if (d == DIR_HOLD)
			return HOLD_PATTERN;
		if (gap)
			return 4'h0;
		if (half)
			idx = (d == DIR_FWD) ? ph : 3'd7 - ph;
		else
			idx = {((d == DIR_FWD) ? ph[1:0] : 2'd3 - ph[1:0]), 1'b0};
		return HALF_SEQ[idx*4 +: 4];
	endfunction

	// Advances the predicted sequencer by one word and returns the coil result it gives.
	function automatic out_word_t step_sequencer(input in_word_t w);
		out_word_t r;
		logic [16:0] seg_len;
		r = '0;
		if (w.kind == KIND_START) begin
			mv_mode = w.move_mode;
			mv_half = w.half_step;
			mv_cycles_left = w.cycles;
			mv_phase = '0;
			seg_timer = '0;
			in_gap = 1'b0;
			moving = (w.cycles != 8'd0);
		end else if (moving) begin
			r.right_coils = motor_coils(wheel_dir(mv_mode, 1'b0), mv_phase, mv_half, in_gap);
			r.left_coils = motor_coils(wheel_dir(mv_mode, 1'b1), mv_phase, mv_half, in_gap);
			if (in_gap)
				seg_len = {1'b0, off_ticks};
			else
				seg_len = (on_ticks == 16'd0) ? 17'd1 : {1'b0, on_ticks};
			seg_timer = seg_timer + 17'd1;
			if (seg_timer >= seg_len) begin
				seg_timer = '0;
				if (!in_gap && off_ticks != 16'd0) begin
					in_gap = 1'b1;
				end else begin
					in_gap = 1'b0;
					if (mv_phase >= (mv_half ? LAST_HALF : LAST_FULL)) begin
						mv_phase = '0;
						mv_cycles_left = mv_cycles_left - 8'd1;
						if (mv_cycles_left == 8'd0) begin
							moving = 1'b0;
							r.done_res = 1'b1;
						end
					end else begin
						mv_phase = mv_phase + 3'd1;
					end
				end
			end
		end
		r.busy_res = moving;
		return r;
	endfunction

	// A tick word carries random values in the fields that it does not use.
	function automatic in_word_t tick_word();
		in_word_t w;
		w.kind = KIND_TICK;
		w.move_mode = 3'($urandom_range(7));
		w.half_step = 1'($urandom_range(1));
		w.cycles = 8'($urandom_range(255));
		return w;
	endfunction

	function automatic in_word_t start_word(input logic [2:0] mode, input logic half,
			input logic [7:0] cycles);
		in_word_t w;
		w.kind = KIND_START;
		w.move_mode = mode;
		w.half_step = half;
		w.cycles = cycles;
		return w;
	endfunction

	task automatic add_word(input in_word_t w);
		pending_words.push_back(w);
		words_queued++;
	endtask

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= REPORT_MAX)
			$display("%s", msg);
	endtask

	// Waits until every queued word has returned its result, then lets the pipeline settle.
	task automatic drain_results();
		while (results_seen < words_queued)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic set_timing(input logic [15:0] on, input logic [15:0] off);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_ON_TIME;
		cfg_data <= on;
		@(posedge clk);
		cfg_index <= CFG_OFF_TIME;
		cfg_data <= off;
		@(posedge clk);
		cfg_we <= 1'b0;
		on_ticks = on;
		off_ticks = off;
	endtask

	// Mostly complete moves with random content, plus aborted moves, zero-cycle starts
	// and stray ticks. The phase may open with ticks that carry on the previous move.
	task automatic queue_moves(input int n, input int on, input int off);
		int count;
		int roll;
		int ticks;
		int span;
		int cycles;
		logic half;
		count = 0;
		ticks = $urandom_range(1, 8);
		while (count < n) begin
			roll = $urandom_range(99);
			if (roll >= 8) begin
				half = 1'($urandom_range(1));
				if (roll < 12)
					cycles = 0;
				else if (roll < 17)
					cycles = $urandom_range(255);
				else
					cycles = $urandom_range(1, 3);
				span = cycles * (half ? 8 : 4) * ((on == 0 ? 1 : on) + off);
				if (roll < 12)
					ticks = $urandom_range(0, 4);
				else if (span > 150 || $urandom_range(99) < 15)
					ticks = $urandom_range(1, span > 150 ? 150 : span);
				else
					ticks = span + $urandom_range(0, 3);
				add_word(start_word(3'($urandom_range(7)), half, 8'(cycles)));
				count++;
			end else if (count != 0) begin
				ticks = $urandom_range(1, 6);
			end
			repeat (ticks) begin
				add_word(tick_word());
				count++;
			end
		end
	endtask

	task automatic run_phase(input int on, input int off, input int n, input int idling);
		drain_results();
		set_timing(16'(on), 16'(off));
		case (idling)
			0: begin sender_idle_pct = 0; recv_stall_pct = 0; end
			1: begin sender_idle_pct = 62; recv_stall_pct = 0; end
			2: begin sender_idle_pct = 0; recv_stall_pct = 62; end
			default: begin sender_idle_pct = 13; recv_stall_pct = 13; end
		endcase
		queue_moves(n, on, off);
	endtask

	// Driver: presents queued words and predicts the result of each accepted one.
	always @(posedge clk or negedge arst_n) begin : drive_words
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else begin
			if (in_valid && in_ready)
				expected_results.push_back(step_sequencer(in_data));
			if (!in_valid || in_ready) begin
				if (pending_words.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					in_data <= pending_words.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each result word against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin : check_results
		out_word_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					note_failure($sformatf("unexpected result right %h left %h busy %b done %b",
						out_data.right_coils, out_data.left_coils,
						out_data.busy_res, out_data.done_res));
				end else begin
					want = expected_results.pop_front();
					if (out_data.right_coils !== want.right_coils ||
							out_data.left_coils !== want.left_coils ||
							out_data.busy_res !== want.busy_res ||
							out_data.done_res !== want.done_res)
						note_failure($sformatf({"result %0d mismatch: expected right %h left %h",
							" busy %b done %b, got right %h left %h busy %b done %b"},
							results_seen, want.right_coils, want.left_coils, want.busy_res,
							want.done_res, out_data.right_coils, out_data.left_coils,
							out_data.busy_res, out_data.done_res));
				end
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Timeout guard.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Reset timing: idle tick, zero-cycle start, longest move, abort and restart.
		add_word(tick_word());
		add_word(start_word(MODE_BOTH_FWD, 1'b0, 8'd0));
		add_word(start_word(MODE_RIGHT_BACK, 1'b1, 8'd255));
		add_word(tick_word());
		add_word(start_word(MODE_SPOT_LEFT, 1'b0, 8'd1));
		add_word(tick_word());
		drain_results();

		// Shortest timing: one complete full-step cycle up to its done mark, then every mode.
		set_timing(16'd1, 16'd0);
		add_word(start_word(MODE_BOTH_FWD, 1'b0, 8'd1));
		repeat (5) add_word(tick_word());
		for (int m = 1; m < 8; m++) begin
			add_word(start_word(m[2:0], m[0], 8'd1));
			add_word(tick_word());
		end

		run_phase(1, 0, 200, 0);
		run_phase(2, 1, 200, 1);
		run_phase(4, 2, 200, 2);
		// Shorter segments right after longer ones end a running segment early.
		run_phase(1, 0, 150, 3);
		run_phase(0, 3, 200, 0);
		run_phase(3, 65535, 60, 1);
		run_phase(65535, 0, 60, 2);
		run_phase(65535, 65535, 40, 3);
		run_phase(1, 1, 200, 0);
		run_phase(2, 0, 200, 1);
		run_phase(3, 2, 200, 2);
		run_phase(1, 3, 150, 3);

		drain_results();
		repeat (5) @(posedge clk);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

@@ dual_stepper_sequencer.f @@
hdl/dss_pkg.sv
hdl/dss_seq.sv
hdl/dual_stepper_sequencer.sv
hdl/dss_checker.sv
verif/dual_stepper_sequencer_test.sv
